@@ rtl/core/sfr_pkg.sv @@
package sfr_pkg;

  localparam int unsigned DefFrameBytes   = 25;
  localparam int unsigned DefChannelCount = 8;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned RawW        = 11;
  localparam int unsigned ChanW       = 12;
  localparam int unsigned PosW        = 5;
  localparam int unsigned ChIdxW      = $clog2(MaxChannels);
  localparam int unsigned PackBytes   = (MaxChannels * RawW + ByteW - 1) / ByteW;

  localparam logic [ByteW-1:0] SyncByte = 8'h0F;
  localparam int unsigned FailsafeByte  = 23;
  localparam int unsigned FailsafeBit   = 3;

  localparam int unsigned RawLow  = 172;
  localparam int unsigned RawHigh = 1811;
  localparam int unsigned Divisor = RawHigh - RawLow;
  localparam int unsigned Scale   = 1000;
  localparam int unsigned OutBase = 1000;

  localparam int unsigned ScaledW    = 21;
  localparam int unsigned RecipShift = 32;
  localparam int unsigned RecipW     = 22;
  localparam longint unsigned RecipMul =
    ((64'd1 << RecipShift) + 64'(Divisor) - 64'd1) / 64'(Divisor);

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [MaxChannels-1:0][RawW-1:0] raw;
    logic                             failsafe;
  } frame_t;

endpackage

@@ rtl/core/sfr_front.sv @@
module sfr_front #(
  parameter int unsigned FRAME_BYTES = sfr_pkg::DefFrameBytes
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [sfr_pkg::ByteW-1:0] rx_data_i,
  output logic                   full_o,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output sfr_pkg::frame_t        frame_o
);
  import sfr_pkg::*;

  localparam int unsigned IdxW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] store_q [FRAME_BYTES];
  logic             last;
  logic             take;
  logic [PackBytes*ByteW-1:0] packed_bytes;

  assign last     = (pos_q == LastPos);
  assign full_o   = q_full_i && last;
  assign take     = push_i && !full_o && ((pos_q != '0) || (rx_data_i == SyncByte));
  assign q_push_o = take && last;

  always_comb begin
    pos_d = pos_q;
    if (take) begin
      pos_d = last ? '0 : pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      store_q[pos_q[IdxW-1:0]] <= rx_data_i;
    end
  end

  always_comb begin
    for (int i = 0; i < PackBytes; i++) begin
      packed_bytes[i*ByteW +: ByteW] = store_q[i+1];
    end
    for (int k = 0; k < MaxChannels; k++) begin
      frame_o.raw[k] = packed_bytes[k*RawW +: RawW];
    end
    frame_o.failsafe = (pos_q == PosW'(FailsafeByte)) ? rx_data_i[FailsafeBit]
                                                       : store_q[FailsafeByte][FailsafeBit];
  end

endmodule

@@ rtl/core/sfr_queue.sv @@
module sfr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sfr_pkg::frame_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sfr_pkg::frame_t data_o
);
  import sfr_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  frame_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/sfr_back.sv @@
module sfr_back #(
  parameter int unsigned CHANNEL_COUNT = sfr_pkg::DefChannelCount
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  sfr_pkg::frame_t frame_i,
  output logic            q_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [sfr_pkg::MaxChannels-1:0][sfr_pkg::ChanW-1:0] chan_o,
  output logic            failsafe_o
);
  import sfr_pkg::*;

  localparam int unsigned ProdW = ScaledW + RecipW;
  localparam logic [ChIdxW-1:0] LastCh = ChIdxW'(CHANNEL_COUNT - 1);

  typedef enum logic [1:0] {StIdle, StIssue, StDrain} state_e;

  state_e              state_q;
  logic [ChIdxW-1:0]   ch_q;
  logic                out_valid_q;
  logic                issue;
  logic                transfer;

  logic [RawW-1:0]     raw;
  logic                raw_neg;
  logic [RawW-1:0]     raw_mag;

  logic                v1_q, v2_q;
  logic [ChIdxW-1:0]   idx1_q, idx2_q;
  logic                neg1_q, neg2_q;
  logic [ScaledW-1:0]  num1_q;
  logic [ProdW-1:0]    prod;
  logic [RawW-1:0]     quot2_q;

  logic [MaxChannels-1:0][ChanW-1:0] work_q;

  assign issue    = (state_q == StIssue);
  assign transfer = (state_q == StDrain) && !v1_q && !v2_q && (!out_valid_q || pop_i);
  assign q_pop_o  = transfer;
  assign empty_o  = !out_valid_q;

  assign raw     = frame_i.raw[ch_q];
  assign raw_neg = (raw < RawW'(RawLow));
  assign raw_mag = raw_neg ? RawW'(RawLow) - raw : raw - RawW'(RawLow);
  assign prod    = ProdW'(num1_q) * ProdW'(RecipMul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_i && out_valid_q && !transfer) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          ch_q <= '0;
          if (!q_empty_i) begin
            state_q <= StIssue;
          end
        end
        StIssue: begin
          if (ch_q == LastCh) begin
            state_q <= StDrain;
          end else begin
            ch_q <= ch_q + ChIdxW'(1);
          end
        end
        StDrain: begin
          if (transfer) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (transfer) begin
      for (int k = 0; k < MaxChannels; k++) begin
        chan_o[k] <= (k < CHANNEL_COUNT) ? work_q[k] : '0;
      end
      failsafe_o <= frame_i.failsafe;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q  <= ch_q;
    neg1_q  <= raw_neg;
    num1_q  <= ScaledW'(raw_mag) * ScaledW'(Scale);
    idx2_q  <= idx1_q;
    neg2_q  <= neg1_q;
    quot2_q <= prod[RecipShift +: RawW];
    if (v2_q) begin
      work_q[idx2_q] <= neg2_q ? ChanW'(OutBase) - ChanW'(quot2_q)
                               : ChanW'(OutBase) + ChanW'(quot2_q);
    end
  end

endmodule

@@ rtl/core/sbus_frame_receiver_top.sv @@
// Channel   Ports                               Handshake
// input     rx_data_i                           push / full
// result    chan0_o..chan7_o, failsafe_flag_o   empty / pop
//
// One byte is taken every cycle while full is low; full rises only on the last byte of a frame
// while both frame queue slots are taken.
// After the last byte, each channel passes in turn through the shared scale pipeline
// (one constant multiply, one reciprocal multiply); the result is then registered.
// Reset returns the byte counter to idle; the frame bytes need no clearing.
// A stalled pop holds the result; the two-frame queue absorbs further frames.
module sbus_frame_receiver_top #(
  parameter int unsigned FRAME_BYTES   = sfr_pkg::DefFrameBytes,
  parameter int unsigned CHANNEL_COUNT = sfr_pkg::DefChannelCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_data_i,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] chan0_o,
  output logic [11:0] chan1_o,
  output logic [11:0] chan2_o,
  output logic [11:0] chan3_o,
  output logic [11:0] chan4_o,
  output logic [11:0] chan5_o,
  output logic [11:0] chan6_o,
  output logic [11:0] chan7_o,
  output logic        failsafe_flag_o
);
  import sfr_pkg::*;

  logic   q_push, q_full, q_pop, q_empty;
  frame_t q_in, q_out;
  logic [MaxChannels-1:0][ChanW-1:0] chan;

  sfr_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .rx_data_i (rx_data_i),
    .full_o    (full),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .frame_o   (q_in)
  );

  sfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  sfr_back #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .frame_i    (q_out),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .chan_o     (chan),
    .failsafe_o (failsafe_flag_o)
  );

  assign chan0_o = chan[0];
  assign chan1_o = chan[1];
  assign chan2_o = chan[2];
  assign chan3_o = chan[3];
  assign chan4_o = chan[4];
  assign chan5_o = chan[5];
  assign chan6_o = chan[6];
  assign chan7_o = chan[7];

endmodule
